/* rtl/core/bpc_pkg.sv */
// shared constants and register codes for the barometric pressure compensation block
package bpc_pkg;

  // default oversampling setting of the pressure conversion
  localparam int unsigned OVERSAMPLING_DEFAULT = 2;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4
  } cfg_reg_t;

  // field widths
  localparam int unsigned RAW_T_W = 16;
  localparam int unsigned RAW_P_W = 18;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned PRESS_W = 17;

  // divider sizes: temperature quotient and pressure quotient
  localparam int unsigned DIV1_NUM_W = 27;
  localparam int unsigned DIV1_DEN_W = 19;
  localparam int unsigned DIV2_NUM_W = 32;
  localparam int unsigned DIV2_DEN_W = 17;

  // compensation constants
  localparam int B6_OFFSET      = 4000;
  localparam int TEMP_ROUND     = 8;
  localparam int TEMP_MIN       = -32768;
  localparam int TEMP_MAX       = 32767;
  localparam int B4_OFFSET      = 32768;
  localparam int B7_SCALE       = 50000;
  localparam int PRESS_SQ_COEF  = 3038;
  localparam int PRESS_LIN_COEF = -7357;
  localparam int PRESS_OFFSET   = 3791;
  localparam int PRESS_MAX      = 131071;

endpackage

/* rtl/core/bpc_stage.sv */
// one pipeline register with valid/ready flow control
module bpc_stage #(
  parameter int unsigned W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         occupied;
  logic [W-1:0] payload;

  // stage takes a new item when empty or when its item moves on
  assign in_ready  = !occupied || out_ready;
  assign out_valid = occupied;
  assign out_data  = payload;

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= 1'b0;
    end else if (in_ready) begin
      occupied <= in_valid;
    end
  end

  // data register, loaded on transfer only
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      payload <= in_data;
    end
  end

endmodule

/* rtl/core/bpc_udiv.sv */
// pipelined unsigned restoring divider, one quotient bit per stage, side data carried along
module bpc_udiv #(
  parameter int unsigned NUM_W  = 8,
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  typedef struct packed {
    logic [SIDE_W-1:0] side;
    logic [DEN_W-1:0]  den;
    logic [DEN_W-1:0]  rem;
    logic [NUM_W-1:0]  dq;
  } step_t;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  function automatic step_t div_step(input step_t a);
    logic [DEN_W:0] trial;
    logic           ge;
    step_t          r;
    trial  = {a.rem, a.dq[NUM_W-1]};
    ge     = (trial >= {1'b0, a.den});
    r      = a;
    r.rem  = ge ? DEN_W'(trial - {1'b0, a.den}) : trial[DEN_W-1:0];
    r.dq   = {a.dq[NUM_W-2:0], ge};
    return r;
  endfunction

  step_t first;
  step_t stg_d [NUM_W];
  step_t stg_q [NUM_W];
  logic  vld   [NUM_W];
  logic  rdy   [NUM_W];

  assign first = '{side: side_in, den: den, rem: '0, dq: num};

  // one register stage per quotient bit
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic stg_in_valid;
    logic stg_out_ready;

    if (k == 0) begin : g_head
      assign stg_d[k]     = div_step(first);
      assign stg_in_valid = in_valid;
      assign in_ready     = rdy[k];
    end else begin : g_body
      assign stg_d[k]     = div_step(stg_q[k-1]);
      assign stg_in_valid = vld[k-1];
    end

    if (k == NUM_W - 1) begin : g_tail
      assign stg_out_ready = out_ready;
    end else begin : g_mid
      assign stg_out_ready = rdy[k+1];
    end

    bpc_stage #(.W($bits(step_t))) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_in_valid),
      .in_ready  (rdy[k]),
      .in_data   (stg_d[k]),
      .out_valid (vld[k]),
      .out_ready (stg_out_ready),
      .out_data  (stg_q[k])
    );
  end

  assign out_valid = vld[NUM_W-1];
  assign quot      = stg_q[NUM_W-1].dq;
  assign side_out  = stg_q[NUM_W-1].side;

  // remainder must end below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stg_q[NUM_W-1].rem < stg_q[NUM_W-1].den))
    else $error("divider remainder not below divisor");

  // caller replaces a zero divisor before it enters
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> (den != '0))
    else $error("zero divisor entered divider");

endmodule

/* rtl/core/barometric_pressure_compensation.sv */
// The path from input transfer to result valid holds 1 + 27 + 7 + 32 + 4 register stages.
// Throughput: one sample pair per cycle while the output is not stalled; the two bit-per-stage dividers set the depth.
// A stalled output holds every stage; bubbles are squeezed out ahead of a stall.
// Reset clears all stage valid bits and the five coefficient registers to zero.
// Configuration writes are taken every cycle.
module barometric_pressure_compensation #(
  parameter int unsigned OVERSAMPLING = bpc_pkg::OVERSAMPLING_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bpc_pkg::RAW_T_W-1:0]         raw_temperature,
  input  logic [bpc_pkg::RAW_P_W-1:0]         raw_pressure,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bpc_pkg::TEMP_W-1:0]   temperature_tenths,
  output logic [bpc_pkg::PRESS_W-1:0]         pressure_pa,
  output logic                                divide_error,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned B7_MULT   = bpc_pkg::B7_SCALE >> OVERSAMPLING;
  localparam int unsigned B7_MULT_W = $clog2(B7_MULT + 1);
  localparam int unsigned V_W       = 50;
  localparam int unsigned T_W       = V_W + OVERSAMPLING + 1;

  // ---------------------------------------------------------------
  // coefficient registers
  logic [31:0] coef_ac1_ac2, coef_ac3_ac4, coef_ac5_ac6, coef_b1_b2, coef_mc_md;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_ac1_ac2 <= '0;
      coef_ac3_ac4 <= '0;
      coef_ac5_ac6 <= '0;
      coef_b1_b2   <= '0;
      coef_mc_md   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (bpc_pkg::cfg_reg_t'(cfg_index))
        bpc_pkg::REG_AC1_AC2: coef_ac1_ac2 <= cfg_data;
        bpc_pkg::REG_AC3_AC4: coef_ac3_ac4 <= cfg_data;
        bpc_pkg::REG_AC5_AC6: coef_ac5_ac6 <= cfg_data;
        bpc_pkg::REG_B1_B2:   coef_b1_b2   <= cfg_data;
        bpc_pkg::REG_MC_MD:   coef_mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic        [15:0] ac4, ac5, ac6;

  assign ac1 = coef_ac1_ac2[31:16];
  assign ac2 = coef_ac1_ac2[15:0];
  assign ac3 = coef_ac3_ac4[31:16];
  assign ac4 = coef_ac3_ac4[15:0];
  assign ac5 = coef_ac5_ac6[31:16];
  assign ac6 = coef_ac5_ac6[15:0];
  assign b1  = coef_b1_b2[31:16];
  assign b2  = coef_b1_b2[15:0];
  assign mc  = coef_mc_md[31:16];
  assign md  = coef_mc_md[15:0];

  // ---------------------------------------------------------------
  // stage payloads
  typedef struct packed {
    logic signed [33:0] prod;
    logic [17:0]        up;
  } s1_t;

  typedef struct packed {
    logic signed [18:0] x1;
    logic               neg;
    logic               err;
    logic [17:0]        up;
  } side1_t;

  typedef struct packed {
    logic signed [27:0] b6;
    logic signed [15:0] temp;
    logic               err;
    logic [17:0]        up;
  } s3_t;

  typedef struct packed {
    logic [53:0]        sqr;
    logic signed [43:0] pac2;
    logic signed [43:0] pac3;
    logic signed [15:0] temp;
    logic               err;
    logic [17:0]        up;
  } s4_t;

  typedef struct packed {
    logic signed [37:0] pb2lo;
    logic signed [37:0] pb2hi;
    logic signed [37:0] pb1lo;
    logic signed [37:0] pb1hi;
    logic signed [43:0] pac2;
    logic signed [43:0] pac3;
    logic signed [15:0] temp;
    logic               err;
    logic [17:0]        up;
  } s5_t;

  typedef struct packed {
    logic signed [58:0] b2sq;
    logic signed [58:0] b1sq;
    logic signed [43:0] pac2;
    logic signed [43:0] pac3;
    logic signed [15:0] temp;
    logic               err;
    logic [17:0]        up;
  } s6_t;

  typedef struct packed {
    logic signed [V_W-1:0] v;
    logic signed [43:0]    y;
    logic signed [15:0]    temp;
    logic                  err;
    logic [17:0]           up;
  } s7_t;

  typedef struct packed {
    logic [31:0]        b3lo;
    logic [31:0]        w;
    logic signed [15:0] temp;
    logic               err;
    logic [17:0]        up;
  } s8_t;

  typedef struct packed {
    logic [31:0]        b4prod;
    logic [31:0]        b7;
    logic signed [15:0] temp;
    logic               err;
  } s9_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic               err;
    logic               sc;
  } side2_t;

  typedef struct packed {
    logic [32:0]        p;
    logic [49:0]        sqp;
    logic signed [47:0] x2p;
    logic signed [15:0] temp;
    logic               err;
  } s11_t;

  typedef struct packed {
    logic [32:0]        p;
    logic [45:0]        x1s;
    logic signed [31:0] x2s;
    logic signed [15:0] temp;
    logic               err;
  } s12_t;

  typedef struct packed {
    logic [32:0]        p;
    logic signed [43:0] r;
    logic signed [15:0] temp;
    logic               err;
  } s13_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [16:0]        press;
    logic               err;
  } out_t;

  // ---------------------------------------------------------------
  // stage 1: (UT - AC6) * AC5
  s1_t                s1_in, s1_q;
  logic               s1_valid, s1_ready;
  logic signed [16:0] s1_diff;

  always_comb begin
    s1_diff    = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
    s1_in.prod = s1_diff * $signed({1'b0, ac5});
    s1_in.up   = raw_pressure;
  end

  bpc_stage #(.W($bits(s1_t))) u_s1 (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(s1_in),
    .out_valid(s1_valid), .out_ready(s1_ready), .out_data(s1_q)
  );

  // divider 1 operands: MC * 2048 over X1 + MD, as magnitudes and sign
  logic signed [18:0]                 d1_x1;
  logic signed [19:0]                 d1_den;
  logic [19:0]                        d1_den_abs;
  logic [bpc_pkg::DIV1_DEN_W-1:0]     d1_den_mag;
  logic [bpc_pkg::DIV1_NUM_W-1:0]     d1_num_raw, d1_num_mag;
  logic                               d1_zero;
  side1_t                             d1_side_in, d1_side_out;
  logic [bpc_pkg::DIV1_NUM_W-1:0]     d1_quot;
  logic                               d1_valid, d1_ready;

  always_comb begin
    d1_x1      = s1_q.prod[33:15];
    d1_den     = d1_x1 + md;
    d1_zero    = (d1_den == '0);
    d1_den_abs = d1_den[19] ? 20'(-d1_den) : d1_den;
    d1_den_mag = d1_zero ? bpc_pkg::DIV1_DEN_W'(1) : d1_den_abs[bpc_pkg::DIV1_DEN_W-1:0];
    d1_num_raw = {mc, 11'b0};
    d1_num_mag = mc[15] ? bpc_pkg::DIV1_NUM_W'(-d1_num_raw) : d1_num_raw;
    d1_side_in = '{x1: d1_x1, neg: mc[15] ^ d1_den[19], err: d1_zero, up: s1_q.up};
  end

  bpc_udiv #(
    .NUM_W(bpc_pkg::DIV1_NUM_W), .DEN_W(bpc_pkg::DIV1_DEN_W), .SIDE_W($bits(side1_t))
  ) u_div1 (
    .clk(clk), .rst(rst),
    .in_valid(s1_valid), .in_ready(s1_ready),
    .num(d1_num_mag), .den(d1_den_mag), .side_in(d1_side_in),
    .out_valid(d1_valid), .out_ready(d1_ready),
    .quot(d1_quot), .side_out(d1_side_out)
  );

  // stage 3: B5, B6 and saturated temperature
  s3_t                s3_in, s3_q;
  logic               s3_valid, s3_ready;
  logic signed [27:0] s3_x2;
  logic signed [28:0] s3_b5, s3_tr, s3_t5;

  always_comb begin
    s3_x2 = d1_side_out.neg ? -28'(d1_quot) : 28'(d1_quot);
    s3_b5 = s3_x2 + d1_side_out.x1;
    s3_tr = s3_b5 + 29'(bpc_pkg::TEMP_ROUND);
    s3_t5 = s3_tr >>> 4;
    s3_in.b6 = 28'(s3_b5 - 29'(bpc_pkg::B6_OFFSET));
    if (s3_t5 > 29'(bpc_pkg::TEMP_MAX)) begin
      s3_in.temp = 16'(bpc_pkg::TEMP_MAX);
    end else if (s3_t5 < 29'(bpc_pkg::TEMP_MIN)) begin
      s3_in.temp = 16'(bpc_pkg::TEMP_MIN);
    end else begin
      s3_in.temp = s3_t5[15:0];
    end
    s3_in.err = d1_side_out.err;
    s3_in.up  = d1_side_out.up;
  end

  bpc_stage #(.W($bits(s3_t))) u_s3 (
    .clk(clk), .rst(rst),
    .in_valid(d1_valid), .in_ready(d1_ready), .in_data(s3_in),
    .out_valid(s3_valid), .out_ready(s3_ready), .out_data(s3_q)
  );

  // stage 4: B6 squared, AC2 * B6, AC3 * B6
  s4_t                s4_in, s4_q;
  logic               s4_valid, s4_ready;
  logic signed [55:0] s4_sqfull;

  always_comb begin
    s4_sqfull  = s3_q.b6 * s3_q.b6;
    s4_in.sqr  = s4_sqfull[53:0];
    s4_in.pac2 = ac2 * s3_q.b6;
    s4_in.pac3 = ac3 * s3_q.b6;
    s4_in.temp = s3_q.temp;
    s4_in.err  = s3_q.err;
    s4_in.up   = s3_q.up;
  end

  bpc_stage #(.W($bits(s4_t))) u_s4 (
    .clk(clk), .rst(rst),
    .in_valid(s3_valid), .in_ready(s3_ready), .in_data(s4_in),
    .out_valid(s4_valid), .out_ready(s4_ready), .out_data(s4_q)
  );

  // stage 5: B2 * sq and B1 * sq as two partial products each
  s5_t         s5_in, s5_q;
  logic        s5_valid, s5_ready;
  logic [41:0] s5_sq;
  logic [20:0] s5_lo, s5_hi;

  always_comb begin
    s5_sq       = s4_q.sqr[53:12];
    s5_lo       = s5_sq[20:0];
    s5_hi       = s5_sq[41:21];
    s5_in.pb2lo = b2 * $signed({1'b0, s5_lo});
    s5_in.pb2hi = b2 * $signed({1'b0, s5_hi});
    s5_in.pb1lo = b1 * $signed({1'b0, s5_lo});
    s5_in.pb1hi = b1 * $signed({1'b0, s5_hi});
    s5_in.pac2  = s4_q.pac2;
    s5_in.pac3  = s4_q.pac3;
    s5_in.temp  = s4_q.temp;
    s5_in.err   = s4_q.err;
    s5_in.up    = s4_q.up;
  end

  bpc_stage #(.W($bits(s5_t))) u_s5 (
    .clk(clk), .rst(rst),
    .in_valid(s4_valid), .in_ready(s4_ready), .in_data(s5_in),
    .out_valid(s5_valid), .out_ready(s5_ready), .out_data(s5_q)
  );

  // stage 6: combine partial products
  s6_t  s6_in, s6_q;
  logic s6_valid, s6_ready;

  always_comb begin
    s6_in.b2sq = (s5_q.pb2hi <<< 21) + s5_q.pb2lo;
    s6_in.b1sq = (s5_q.pb1hi <<< 21) + s5_q.pb1lo;
    s6_in.pac2 = s5_q.pac2;
    s6_in.pac3 = s5_q.pac3;
    s6_in.temp = s5_q.temp;
    s6_in.err  = s5_q.err;
    s6_in.up   = s5_q.up;
  end

  bpc_stage #(.W($bits(s6_t))) u_s6 (
    .clk(clk), .rst(rst),
    .in_valid(s5_valid), .in_ready(s5_ready), .in_data(s6_in),
    .out_valid(s6_valid), .out_ready(s6_ready), .out_data(s6_q)
  );

  // stage 7: AC1 * 4 + X3 for B3, and the B4 correction sum
  s7_t  s7_in, s7_q;
  logic s7_valid, s7_ready;

  always_comb begin
    s7_in.v    = V_W'((ac1 <<< 2) + (s6_q.b2sq >>> 11) + (s6_q.pac2 >>> 11));
    s7_in.y    = 44'((s6_q.pac3 >>> 13) + (s6_q.b1sq >>> 16) + 2);
    s7_in.temp = s6_q.temp;
    s7_in.err  = s6_q.err;
    s7_in.up   = s6_q.up;
  end

  bpc_stage #(.W($bits(s7_t))) u_s7 (
    .clk(clk), .rst(rst),
    .in_valid(s6_valid), .in_ready(s6_ready), .in_data(s7_in),
    .out_valid(s7_valid), .out_ready(s7_ready), .out_data(s7_q)
  );

  // stage 8: B3 with division by four toward zero, X3 + 32768 modulo 2^32
  s8_t                   s8_in, s8_q;
  logic                  s8_valid, s8_ready;
  logic signed [T_W-1:0] s8_n, s8_sum;
  logic signed [41:0]    s8_x3;

  always_comb begin
    // a negative numerator gets three added before the floor shift
    s8_n       = (T_W'(s7_q.v) <<< OVERSAMPLING) + T_W'(2);
    s8_sum     = s8_n + (s8_n[T_W-1] ? T_W'(3) : T_W'(0));
    s8_x3      = 42'(s7_q.y >>> 2);
    s8_in.b3lo = 32'(s8_sum >>> 2);
    s8_in.w    = s8_x3[31:0] + 32'(bpc_pkg::B4_OFFSET);
    s8_in.temp = s7_q.temp;
    s8_in.err  = s7_q.err;
    s8_in.up   = s7_q.up;
  end

  bpc_stage #(.W($bits(s8_t))) u_s8 (
    .clk(clk), .rst(rst),
    .in_valid(s7_valid), .in_ready(s7_ready), .in_data(s8_in),
    .out_valid(s8_valid), .out_ready(s8_ready), .out_data(s8_q)
  );

  // stage 9: B4 product and B7, both modulo 2^32
  s9_t         s9_in, s9_q;
  logic        s9_valid, s9_ready;
  logic [31:0] s9_diff;

  always_comb begin
    s9_diff      = 32'(s8_q.up) - s8_q.b3lo;
    s9_in.b4prod = 32'(s8_q.w * ac4);
    s9_in.b7     = 32'(s9_diff * B7_MULT_W'(B7_MULT));
    s9_in.temp   = s8_q.temp;
    s9_in.err    = s8_q.err;
  end

  bpc_stage #(.W($bits(s9_t))) u_s9 (
    .clk(clk), .rst(rst),
    .in_valid(s8_valid), .in_ready(s8_ready), .in_data(s9_in),
    .out_valid(s9_valid), .out_ready(s9_ready), .out_data(s9_q)
  );

  // divider 2 operands: B7 * 2 / B4, or B7 / B4 doubled when B7 has its top bit set
  logic [bpc_pkg::DIV2_DEN_W-1:0] d2_b4, d2_den;
  logic [bpc_pkg::DIV2_NUM_W-1:0] d2_num, d2_quot;
  logic                           d2_zero;
  side2_t                         d2_side_in, d2_side_out;
  logic                           d2_valid, d2_ready;

  always_comb begin
    d2_b4      = s9_q.b4prod[31:15];
    d2_zero    = (d2_b4 == '0);
    d2_den     = d2_zero ? bpc_pkg::DIV2_DEN_W'(1) : d2_b4;
    d2_num     = s9_q.b7[31] ? s9_q.b7 : {s9_q.b7[30:0], 1'b0};
    d2_side_in = '{temp: s9_q.temp, err: s9_q.err | d2_zero, sc: s9_q.b7[31]};
  end

  bpc_udiv #(
    .NUM_W(bpc_pkg::DIV2_NUM_W), .DEN_W(bpc_pkg::DIV2_DEN_W), .SIDE_W($bits(side2_t))
  ) u_div2 (
    .clk(clk), .rst(rst),
    .in_valid(s9_valid), .in_ready(s9_ready),
    .num(d2_num), .den(d2_den), .side_in(d2_side_in),
    .out_valid(d2_valid), .out_ready(d2_ready),
    .quot(d2_quot), .side_out(d2_side_out)
  );

  // stage 11: p, (p >> 8) squared, linear term
  s11_t        s11_in, s11_q;
  logic        s11_valid, s11_ready;
  logic [24:0] s11_pp;

  always_comb begin
    s11_in.p    = d2_side_out.sc ? {d2_quot, 1'b0} : {1'b0, d2_quot};
    s11_pp      = s11_in.p[32:8];
    s11_in.sqp  = s11_pp * s11_pp;
    s11_in.x2p  = 14'(bpc_pkg::PRESS_LIN_COEF) * $signed({1'b0, s11_in.p});
    s11_in.temp = d2_side_out.temp;
    s11_in.err  = d2_side_out.err;
  end

  bpc_stage #(.W($bits(s11_t))) u_s11 (
    .clk(clk), .rst(rst),
    .in_valid(d2_valid), .in_ready(d2_ready), .in_data(s11_in),
    .out_valid(s11_valid), .out_ready(s11_ready), .out_data(s11_q)
  );

  // stage 12: square term scaled by its coefficient
  s12_t        s12_in, s12_q;
  logic        s12_valid, s12_ready;
  logic [61:0] s12_x1m;

  always_comb begin
    s12_x1m     = s11_q.sqp * 12'(bpc_pkg::PRESS_SQ_COEF);
    s12_in.p    = s11_q.p;
    s12_in.x1s  = s12_x1m[61:16];
    s12_in.x2s  = 32'(s11_q.x2p >>> 16);
    s12_in.temp = s11_q.temp;
    s12_in.err  = s11_q.err;
  end

  bpc_stage #(.W($bits(s12_t))) u_s12 (
    .clk(clk), .rst(rst),
    .in_valid(s11_valid), .in_ready(s11_ready), .in_data(s12_in),
    .out_valid(s12_valid), .out_ready(s12_ready), .out_data(s12_q)
  );

  // stage 13: pressure correction
  s13_t               s13_in, s13_q;
  logic               s13_valid, s13_ready;
  logic signed [47:0] s13_sum;

  always_comb begin
    s13_sum     = $signed({2'b00, s12_q.x1s}) + 48'(s12_q.x2s) +
                  48'(bpc_pkg::PRESS_OFFSET);
    s13_in.p    = s12_q.p;
    s13_in.r    = 44'(s13_sum >>> 4);
    s13_in.temp = s12_q.temp;
    s13_in.err  = s12_q.err;
  end

  bpc_stage #(.W($bits(s13_t))) u_s13 (
    .clk(clk), .rst(rst),
    .in_valid(s12_valid), .in_ready(s12_ready), .in_data(s13_in),
    .out_valid(s13_valid), .out_ready(s13_ready), .out_data(s13_q)
  );

  // stage 14: final pressure, saturation, zero results on divide error
  out_t               s14_in, s14_q;
  logic signed [44:0] s14_pf;

  always_comb begin
    s14_pf = $signed({12'b0, s13_q.p}) + 45'(s13_q.r);
    if (s13_q.err) begin
      s14_in.press = '0;
    end else if (s14_pf < 45'sd0) begin
      s14_in.press = '0;
    end else if (s14_pf > 45'(bpc_pkg::PRESS_MAX)) begin
      s14_in.press = 17'(bpc_pkg::PRESS_MAX);
    end else begin
      s14_in.press = s14_pf[16:0];
    end
    s14_in.temp = s13_q.err ? 16'sd0 : s13_q.temp;
    s14_in.err  = s13_q.err;
  end

  bpc_stage #(.W($bits(out_t))) u_s14 (
    .clk(clk), .rst(rst),
    .in_valid(s13_valid), .in_ready(s13_ready), .in_data(s14_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(s14_q)
  );

  assign temperature_tenths = s14_q.temp;
  assign pressure_pa        = s14_q.press;
  assign divide_error       = s14_q.err;

  // a divide error always comes with zero results
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && divide_error |-> (temperature_tenths == '0) && (pressure_pa == '0))
    else $error("divide error with nonzero results");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  // a waiting result holds still until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(s14_q))
    else $error("result changed while waiting");

endmodule

/* tb/tb_barometric_pressure_compensation.sv */
// testbench for the barometric pressure compensation block: directed table then random samples
module tb_barometric_pressure_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OSS = bpc_pkg::OVERSAMPLING_DEFAULT;
  localparam int LATENCY = 71;
  localparam int NUM_RANDOM = 1750;

  typedef struct packed {
    logic signed [bpc_pkg::TEMP_W-1:0] temp;
    logic [bpc_pkg::PRESS_W-1:0] press;
    logic err;
  } reading_t;

  // one row of the directed table; check_known selects a typed-in result
  typedef struct {
    logic [bpc_pkg::RAW_T_W-1:0] ut;
    logic [bpc_pkg::RAW_P_W-1:0] up;
    bit check_known;
    reading_t known;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [bpc_pkg::RAW_T_W-1:0] raw_temperature = '0;
  logic [bpc_pkg::RAW_P_W-1:0] raw_pressure = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [bpc_pkg::TEMP_W-1:0] temperature_tenths;
  logic [bpc_pkg::PRESS_W-1:0] pressure_pa;
  logic divide_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bpc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [31:0] coef [5];
  reading_t expected_readings [$];
  int errors = 0;

  barometric_pressure_compensation #(.OVERSAMPLING(OSS)) i_dut (.*);

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // integer compensation with the current coefficients
  function automatic reading_t compensate(logic [bpc_pkg::RAW_T_W-1:0] ut_in,
                                          logic [bpc_pkg::RAW_P_W-1:0] up_in);
    reading_t r;
    longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut, up;
    longint x1, x2, x3, den, b3, b5, b6, sq, p;
    logic [31:0] b4, b7, t32;
    logic [63:0] prod;
    ac1 = longint'($signed(coef[bpc_pkg::REG_AC1_AC2][31:16]));
    ac2 = longint'($signed(coef[bpc_pkg::REG_AC1_AC2][15:0]));
    ac3 = longint'($signed(coef[bpc_pkg::REG_AC3_AC4][31:16]));
    ac4 = longint'({16'h0, coef[bpc_pkg::REG_AC3_AC4][15:0]});
    ac5 = longint'({16'h0, coef[bpc_pkg::REG_AC5_AC6][31:16]});
    ac6 = longint'({16'h0, coef[bpc_pkg::REG_AC5_AC6][15:0]});
    b1 = longint'($signed(coef[bpc_pkg::REG_B1_B2][31:16]));
    b2 = longint'($signed(coef[bpc_pkg::REG_B1_B2][15:0]));
    mc = longint'($signed(coef[bpc_pkg::REG_MC_MD][31:16]));
    md = longint'($signed(coef[bpc_pkg::REG_MC_MD][15:0]));
    ut = longint'({16'h0, ut_in});
    up = longint'({14'h0, up_in});
    r = '{temp: '0, press: '0, err: 1'b1};
    x1 = shr_floor((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return r;
    x2 = (mc * 2048) / den;
    b5 = x1 + x2;
    r.temp = bpc_pkg::TEMP_W'(sat(shr_floor(b5 + bpc_pkg::TEMP_ROUND, 4),
                                  bpc_pkg::TEMP_MIN, bpc_pkg::TEMP_MAX));
    b6 = b5 - bpc_pkg::B6_OFFSET;
    sq = (b6 * b6) >>> 12;
    x1 = shr_floor(b2 * sq, 11);
    x2 = shr_floor(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = ((ac1 * 4 + x3) * (longint'(1) << OSS) + 2) / 4;
    x1 = shr_floor(ac3 * b6, 13);
    x2 = shr_floor(b1 * sq, 16);
    x3 = shr_floor(x1 + x2 + 2, 2);
    t32 = 32'(x3 + bpc_pkg::B4_OFFSET);
    prod = {32'h0, t32} * ac4;
    b4 = prod[31:0] >> 15;
    if (b4 == 0) begin
      r.temp = '0;
      return r;
    end
    t32 = 32'(up - b3);
    prod = {32'h0, t32} * longint'(bpc_pkg::B7_SCALE >> OSS);
    b7 = prod[31:0];
    if (b7 < 32'h8000_0000) p = longint'({b7, 1'b0} / {1'b0, b4});
    else p = longint'(b7 / b4) * 2;
    x1 = (p >>> 8) * (p >>> 8);
    x1 = (x1 * bpc_pkg::PRESS_SQ_COEF) >>> 16;
    x2 = shr_floor(bpc_pkg::PRESS_LIN_COEF * p, 16);
    p = p + shr_floor(x1 + x2 + bpc_pkg::PRESS_OFFSET, 4);
    r.press = bpc_pkg::PRESS_W'(sat(p, 0, bpc_pkg::PRESS_MAX));
    r.err = 1'b0;
    return r;
  endfunction

  // valid stays high across back-to-back writes; the caller drops it after the last one
  task automatic write_coef(bpc_pkg::cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    coef[idx] = val;
  endtask

  // wait until every result is back and the pipe has drained
  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (expected_readings.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic send_sample(logic [bpc_pkg::RAW_T_W-1:0] ut, logic [bpc_pkg::RAW_P_W-1:0] up);
    int gap;
    gap = $urandom_range(0, 6) * ($urandom_range(0, 3) != 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_temperature <= ut;
    raw_pressure <= up;
    do @(posedge clk); while (!in_ready);
    expected_readings.push_back(compensate(ut, up));
  endtask

  task automatic load_set(logic [31:0] a, b, c, d, e);
    drain();
    write_coef(bpc_pkg::REG_AC1_AC2, a);
    write_coef(bpc_pkg::REG_AC3_AC4, b);
    write_coef(bpc_pkg::REG_AC5_AC6, c);
    write_coef(bpc_pkg::REG_B1_B2, d);
    write_coef(bpc_pkg::REG_MC_MD, e);
    cfg_valid <= 1'b0;
  endtask

  // typical sensor coefficients
  task automatic load_typical;
    load_set({16'sd408, -16'sd72}, {-16'sd14383, 16'd32741}, {16'd32757, 16'd23153},
             {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
  endtask

  // result side: random stalls and field checks
  initial begin
    reading_t exp_r;
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_readings.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (temperature_tenths !== exp_r.temp) begin
          $error("temperature_tenths expected %0d got %0d", exp_r.temp, temperature_tenths);
          errors++;
        end
        if (pressure_pa !== exp_r.press) begin
          $error("pressure_pa expected %0d got %0d", exp_r.press, pressure_pa);
          errors++;
        end
        if (divide_error !== exp_r.err) begin
          $error("divide_error expected %0b got %0b", exp_r.err, divide_error);
          errors++;
        end
      end
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    reading_t got;
    int n;
    for (int i = 0; i < 5; i++) coef[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset all coefficients are zero: md + x1 = 0, so a divide error
    rows.push_back('{16'h0000, 18'h00000, 1'b1, '{temp: '0, press: '0, err: 1'b1}});
    rows.push_back('{16'hFFFF, 18'h3FFFF, 1'b1, '{temp: '0, press: '0, err: 1'b1}});
    foreach (rows[i]) begin
      got = compensate(rows[i].ut, rows[i].up);
      if (rows[i].check_known && got !== rows[i].known) begin
        $error("table row %0d: typed result disagrees with prediction", i);
        errors++;
      end
      send_sample(rows[i].ut, rows[i].up);
    end

    // typical coefficients: extremes and datasheet-like readings
    load_typical();
    rows.delete();
    rows.push_back('{16'd27898, 18'd23843, 1'b0, '{default: '0}});
    rows.push_back('{16'h0000, 18'h00000, 1'b0, '{default: '0}});
    rows.push_back('{16'hFFFF, 18'h3FFFF, 1'b0, '{default: '0}});
    rows.push_back('{16'h0000, 18'h3FFFF, 1'b0, '{default: '0}});
    rows.push_back('{16'hFFFF, 18'h00000, 1'b0, '{default: '0}});
    rows.push_back('{16'h5555, 18'h2AAAA, 1'b0, '{default: '0}});
    rows.push_back('{16'hAAAA, 18'h15555, 1'b0, '{default: '0}});
    foreach (rows[i]) send_sample(rows[i].ut, rows[i].up);

    // b4 zero: ac4 = 0 gives a divide error on the pressure side
    load_set({16'sd408, -16'sd72}, {-16'sd14383, 16'd0}, {16'd32757, 16'd23153},
             {16'sd6190, 16'sd4}, {-16'sd8711, 16'sd2868});
    send_sample(16'd27898, 18'd23843);
    // extreme coefficients, saturation both ways
    load_set(32'h7FFF_7FFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h7FFF_7FFF, 32'h7FFF_0001);
    send_sample(16'hFFFF, 18'h3FFFF);
    send_sample(16'h0000, 18'h00000);
    load_set(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_FFFF, 32'h8000_8000, 32'h8000_FFFF);
    send_sample(16'hFFFF, 18'h3FFFF);
    send_sample(16'h0000, 18'h00000);
    send_sample(16'h8000, 18'h20000);

    // random part in phases with fresh coefficient sets
    n = 0;
    while (n < NUM_RANDOM) begin
      case ($urandom_range(0, 3))
        0: load_set($urandom, $urandom, $urandom, $urandom, $urandom);
        1: load_set({$urandom_range(0, 1) ? 32'h7FFF_7FFF : 32'h8000_8000},
                    {16'(-$urandom_range(0, 20000)), 16'($urandom_range(20000, 65535))},
                    {16'($urandom_range(20000, 40000)), 16'($urandom_range(15000, 30000))},
                    $urandom, {16'(-$urandom_range(5000, 12000)), 16'($urandom_range(0, 4000))});
        default: load_typical();
      endcase
      for (int k = 0; k < 150 && n < NUM_RANDOM; k++, n++) begin
        if ($urandom_range(0, 3) != 0)
          send_sample(16'($urandom_range(20000, 36000)), 18'($urandom_range(10000, 120000)));
        else
          send_sample(16'($urandom), 18'($urandom));
      end
    end

    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
